>>> rtl/core/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared widths, codes, state type and the word-unit result structure.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Field widths fixed by the interface
  localparam int REQ_W       = 2;
  localparam int ADDR_W      = 32;
  localparam int STAT_W      = 2;
  localparam int COUNT_W     = 17;
  localparam int UPPER_KB_W  = 22;
  localparam int RESV_W      = 17;
  localparam int CFG_W       = 22;
  localparam int CFG_IDX_W   = 1;

  // Map geometry
  localparam int WORD_BITS   = 32;
  localparam int BIT_IDX_W   = 5;
  localparam int PAGE_SHIFT  = 12;
  localparam int PAGE_NUM_W  = ADDR_W - PAGE_SHIFT;
  localparam int TOTAL_RAW_W = UPPER_KB_W - 1;

  // Defaults and reset values
  localparam int                    DEF_PAGE_COUNT = 65536;
  localparam logic [UPPER_KB_W-1:0] UPPER_KB_RST   = UPPER_KB_W'(261120);
  localparam logic [RESV_W-1:0]     RESV_RST       = RESV_W'(2048);
  localparam logic [UPPER_KB_W:0]   LOW_MEM_KB     = (UPPER_KB_W + 1)'(1024);

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT  = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_NONE  = 2'd3
  } bpa_req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_OOM     = 2'd1,
    STAT_IGNORED = 2'd2
  } bpa_stat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPPER_KB = 1'd0,
    CFG_RESERVED = 1'd1
  } bpa_cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_FREE_RD,
    S_FREE_CHK,
    S_RESP
  } bpa_state_t;

  typedef struct packed {
    logic                 zero_found;
    logic [BIT_IDX_W-1:0] zero_idx;
    logic                 bit_busy;
    logic [WORD_BITS-1:0] set_word;
    logic [WORD_BITS-1:0] clr_word;
    logic [WORD_BITS-1:0] fill_word;
  } bpa_wu_res_t;

endpackage

>>> rtl/core/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator, first fit, one bit per 4 KB page
// Init writes one map word a cycle, then reports; allocate reads and checks
// the map word by word until a clear bit or the page total ends the scan;
// free reads and checks one word; a rejected or unused request just reports.
// Throughput: one beat at a time; busy stays high until the result strobe.
// Reset: synchronous, active low; counts and page total clear, registers
// take their defaults. The map is not cleared: it is only read after an init.
// ----------------------------------------------------------------------------
module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int PAGE_COUNT = DEF_PAGE_COUNT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel
  input  logic                  start,
  output logic                  busy,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [ADDR_W-1:0]     in_address,
  // Result channel
  output logic                  out_valid,
  output logic [ADDR_W-1:0]     out_page_address,
  output logic [STAT_W-1:0]     out_status,
  output logic [COUNT_W-1:0]    out_used_count,
  output logic [COUNT_W-1:0]    out_free_count,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  // The map holds PAGE_COUNT bits packed into 32-bit words. The counters are
  // wide enough for both the reserved count and the largest page total.
  localparam int MAP_WORDS = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WD_W      = $clog2(MAP_WORDS);
  localparam int PC_W      = $clog2(PAGE_COUNT + 1);
  localparam int CNT_W     = (PC_W > COUNT_W) ? PC_W : COUNT_W;

  localparam logic [WD_W-1:0] LAST_WORD = WD_W'(MAP_WORDS - 1);

  // Configuration registers
  logic [UPPER_KB_W-1:0] upper_kb_r;
  logic [RESV_W-1:0]     reserved_r;

  // Sequencer state
  bpa_state_t            state_r, state_nxt;
  logic [WD_W-1:0]       word_r, word_nxt;
  logic [BIT_IDX_W-1:0]  bit_r, bit_nxt;
  logic [CNT_W-1:0]      total_r, total_nxt;
  logic [CNT_W-1:0]      used_r, used_nxt;
  logic [ADDR_W-1:0]     res_addr_r, res_addr_nxt;
  bpa_stat_t             res_stat_r, res_stat_nxt;

  // Result registers
  logic                  out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]     out_addr_r, out_addr_nxt;
  logic [STAT_W-1:0]     out_stat_r, out_stat_nxt;
  logic [COUNT_W-1:0]    out_used_r, out_used_nxt;
  logic [COUNT_W-1:0]    out_free_r, out_free_nxt;

  // Map memory and word unit
  logic                  ram_we;
  logic [WD_W-1:0]       ram_waddr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic [WD_W-1:0]       ram_raddr;
  logic [WORD_BITS-1:0]  ram_rdata;
  bpa_wu_res_t           wu;

  // Helpers
  logic                  accept;
  bpa_req_t              req;
  logic [UPPER_KB_W:0]   kb_sum;
  logic [TOTAL_RAW_W-1:0] total_raw;
  logic [CNT_W-1:0]      init_total;
  logic [PAGE_NUM_W-1:0] free_page;
  logic [WD_W+4:0]       alloc_page;
  logic [WD_W+5:0]       next_base;

  assign accept     = start && (state_r == S_IDLE);
  assign req        = bpa_req_t'(in_req_type);
  assign busy       = (state_r != S_IDLE);

  // Page total from memory size: (1 MB + upper memory) / 4 KB, capped at the
  // map size.
  assign kb_sum     = LOW_MEM_KB + (UPPER_KB_W + 1)'(upper_kb_r);
  assign total_raw  = kb_sum[UPPER_KB_W:2];
  assign init_total = (32'(total_raw) > 32'(PAGE_COUNT)) ? CNT_W'(PAGE_COUNT)
                                                         : CNT_W'(total_raw);

  assign free_page  = in_address[ADDR_W-1:PAGE_SHIFT];
  assign alloc_page = {word_r, wu.zero_idx};
  // Base page of the word after the current one; one extra bit so that the
  // last word does not wrap.
  assign next_base  = {({1'b0, word_r} + (WD_W + 1)'(1)), {BIT_IDX_W{1'b0}}};

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpa_word_unit #(
    .PAGE_COUNT (PAGE_COUNT)
  ) u_word (
    .rd_word  (ram_rdata),
    .bit_sel  (bit_r),
    .word_idx (word_r),
    .reserved (reserved_r),
    .res      (wu)
  );

  // Configuration registers are written whenever the write enable is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_kb_r <= UPPER_KB_RST;
      reserved_r <= RESV_RST;
    end else if (cfg_we) begin
      case (bpa_cfg_t'(cfg_index))
        CFG_UPPER_KB: upper_kb_r <= cfg_wdata[UPPER_KB_W-1:0];
        CFG_RESERVED: reserved_r <= cfg_wdata[RESV_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    bit_r      <= bit_nxt;
    res_addr_r <= res_addr_nxt;
    res_stat_r <= res_stat_nxt;
    out_addr_r <= out_addr_nxt;
    out_stat_r <= out_stat_nxt;
    out_used_r <= out_used_nxt;
    out_free_r <= out_free_nxt;
  end

  // Sequencer: every request ends in S_RESP, which loads the result
  // registers; the strobe then shows for one cycle while the block is
  // already idle again.
  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    bit_nxt       = bit_r;
    total_nxt     = total_r;
    used_nxt      = used_r;
    res_addr_nxt  = res_addr_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = 1'b0;
    out_addr_nxt  = out_addr_r;
    out_stat_nxt  = out_stat_r;
    out_used_nxt  = out_used_r;
    out_free_nxt  = out_free_r;
    ram_we        = 1'b0;
    ram_waddr     = word_r;
    ram_wdata     = wu.set_word;
    ram_raddr     = word_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_addr_nxt = '0;
          res_stat_nxt = STAT_DONE;
          case (req)
            REQ_INIT: begin
              total_nxt = init_total;
              used_nxt  = CNT_W'(reserved_r);
              word_nxt  = '0;
              state_nxt = S_INIT;
            end
            REQ_ALLOC: begin
              word_nxt = '0;
              if (total_r == '0) begin
                res_stat_nxt = STAT_OOM;
                state_nxt    = S_RESP;
              end else begin
                state_nxt = S_ALLOC_RD;
              end
            end
            REQ_FREE: begin
              word_nxt = free_page[WD_W+4:BIT_IDX_W];
              bit_nxt  = free_page[BIT_IDX_W-1:0];
              if (32'(free_page) >= 32'(total_r)) begin
                res_stat_nxt = STAT_IGNORED;
                state_nxt    = S_RESP;
              end else begin
                state_nxt = S_FREE_RD;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      // One map word rewritten each cycle: reserved pages busy, rest free.
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = wu.fill_word;
        if (word_r == LAST_WORD) begin
          state_nxt = S_RESP;
        end else begin
          word_nxt = word_r + WD_W'(1);
        end
      end

      S_ALLOC_RD: begin
        state_nxt = S_ALLOC_CHK;
      end

      // A word with a clear bit ends the scan: the bit is taken if it lies
      // below the page total, otherwise memory is exhausted.
      S_ALLOC_CHK: begin
        if (wu.zero_found) begin
          if (32'(alloc_page) < 32'(total_r)) begin
            ram_we       = 1'b1;
            ram_wdata    = wu.set_word;
            used_nxt     = used_r + CNT_W'(1);
            res_addr_nxt = 32'(alloc_page) << PAGE_SHIFT;
          end else begin
            res_stat_nxt = STAT_OOM;
          end
          state_nxt = S_RESP;
        end else if (32'(next_base) < 32'(total_r)) begin
          word_nxt  = word_r + WD_W'(1);
          state_nxt = S_ALLOC_RD;
        end else begin
          res_stat_nxt = STAT_OOM;
          state_nxt    = S_RESP;
        end
      end

      S_FREE_RD: begin
        state_nxt = S_FREE_CHK;
      end

      // Freeing a page that is already free changes nothing.
      S_FREE_CHK: begin
        if (wu.bit_busy) begin
          ram_we    = 1'b1;
          ram_wdata = wu.clr_word;
          if (used_r != '0) begin
            used_nxt = used_r - CNT_W'(1);
          end
        end else begin
          res_stat_nxt = STAT_IGNORED;
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        out_valid_nxt = 1'b1;
        out_addr_nxt  = res_addr_r;
        out_stat_nxt  = res_stat_r;
        out_used_nxt  = used_r[COUNT_W-1:0];
        if (total_r > used_r) begin
          out_free_nxt = COUNT_W'(total_r - used_r);
        end else begin
          out_free_nxt = '0;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_page_address = out_addr_r;
  assign out_status       = out_stat_r;
  assign out_used_count   = out_used_r;
  assign out_free_count   = out_free_r;

endmodule

>>> rtl/core/bpa_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/bpa_word_unit.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator word unit
// Shared logic on one 32-bit map word: first free bit, bit set and clear,
// and the fill pattern written during initialisation.
// ----------------------------------------------------------------------------
module bpa_word_unit
  import bpa_pkg::*;
#(
  parameter int PAGE_COUNT = DEF_PAGE_COUNT
) (
  input  logic [WORD_BITS-1:0]                                 rd_word,
  input  logic [BIT_IDX_W-1:0]                                 bit_sel,
  input  logic [$clog2((PAGE_COUNT + WORD_BITS - 1) / WORD_BITS)-1:0] word_idx,
  input  logic [RESV_W-1:0]                                    reserved,
  output bpa_wu_res_t                                          res
);

  logic [BIT_IDX_W-1:0] zero_idx;
  logic [WORD_BITS-1:0] sel_mask;
  logic [WORD_BITS-1:0] zero_mask;
  logic [WORD_BITS-1:0] part_mask;
  logic [31:0]          word_ext;
  logic [31:0]          resv_word_ext;

  // Lowest clear bit of the word wins.
  always_comb begin
    zero_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rd_word[i]) begin
        zero_idx = BIT_IDX_W'(i);
      end
    end
  end

  assign sel_mask      = WORD_BITS'(1) << bit_sel;
  assign zero_mask     = WORD_BITS'(1) << zero_idx;
  assign part_mask     = ~({WORD_BITS{1'b1}} << reserved[BIT_IDX_W-1:0]);
  assign word_ext      = 32'(word_idx);
  assign resv_word_ext = 32'(reserved[RESV_W-1:BIT_IDX_W]);

  always_comb begin
    res.zero_found = ~&rd_word;
    res.zero_idx   = zero_idx;
    res.bit_busy   = rd_word[bit_sel];
    res.set_word   = rd_word | zero_mask;
    res.clr_word   = rd_word & ~sel_mask;
    if (word_ext < resv_word_ext) begin
      res.fill_word = {WORD_BITS{1'b1}};
    end else if (word_ext == resv_word_ext) begin
      res.fill_word = part_mask;
    end else begin
      res.fill_word = '0;
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Drives init, allocate, free and unused requests through the command port,
// keeps its own copy of the page map and counters, and compares every result
// beat field by field with the predicted one. Register settings are changed
// only while the block is idle, and the sender idles at several rates.
// ----------------------------------------------------------------------------
module tb;
  import bpa_pkg::*;

  // Map geometry used by the testbench's own page map.
  localparam int PAGE_COUNT  = 65536;
  localparam int MAP_WORDS   = PAGE_COUNT / WORD_BITS;
  // Longest correct quiet stretch is a full allocation scan plus a sender
  // gap, so this leaves a wide margin.
  localparam int QUIET_LIMIT = 40000;
  localparam int UPPER_KB_HI = 4193280;

  // One result beat as the block reports it.
  typedef struct packed {
    logic [ADDR_W-1:0]  page_address;
    bpa_stat_t          status;
    logic [COUNT_W-1:0] used_count;
    logic [COUNT_W-1:0] free_count;
  } reply_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [REQ_W-1:0]     in_req_type;
  logic [ADDR_W-1:0]    in_address;
  logic                 out_valid;
  logic [ADDR_W-1:0]    out_page_address;
  logic [STAT_W-1:0]    out_status;
  logic [COUNT_W-1:0]   out_used_count;
  logic [COUNT_W-1:0]   out_free_count;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  bitmap_page_allocator #(
    .PAGE_COUNT(PAGE_COUNT)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_address      (in_address),
    .out_valid       (out_valid),
    .out_page_address(out_page_address),
    .out_status      (out_status),
    .out_used_count  (out_used_count),
    .out_free_count  (out_free_count),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Free-running clock with a 2 ns period.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predicted allocator state. It mirrors the block from reset onwards and is
  // advanced once for every request beat that the block accepts.
  // --------------------------------------------------------------------------
  logic [UPPER_KB_W-1:0] upper_kb_cfg   = UPPER_KB_RST;
  logic [RESV_W-1:0]     reserved_cfg   = RESV_RST;
  logic [WORD_BITS-1:0]  page_map [MAP_WORDS];
  int                    map_total      = 0;
  int                    pages_taken    = 0;

  reply_t replies_due [$];   // predicted result beats, oldest first
  int     error_count     = 0;
  int     sender_idle_pct = 0;
  int     quiet_cycles    = 0;
  reply_t reply_seen;
  reply_t reply_due;

  // The map starts with every page busy; it is only consulted after an init.
  initial begin
    for (int w = 0; w < MAP_WORDS; w++) page_map[w] = '1;
  end

  // Works out the result of one request and updates the predicted state.
  function automatic reply_t predict_request(input logic [REQ_W-1:0] req,
                                             input logic [ADDR_W-1:0] addr);
    reply_t r;
    int     total;
    int     resv;
    int     page;
    bit     found;
    r        = '0;
    r.status = STAT_DONE;
    case (req)
      REQ_INIT: begin
        // Page total comes from the low megabyte plus the upper memory,
        // saturated at the map size; the lowest pages are reserved.
        total = (int'(LOW_MEM_KB) + int'(upper_kb_cfg)) / 4;
        if (total > PAGE_COUNT) total = PAGE_COUNT;
        map_total = total;
        resv      = int'(reserved_cfg);
        for (int w = 0; w < MAP_WORDS; w++) begin
          if (w * WORD_BITS + WORD_BITS <= resv) begin
            page_map[w] = '1;
          end else if (w * WORD_BITS < resv) begin
            page_map[w] = (32'h1 << (resv - w * WORD_BITS)) - 32'h1;
          end else begin
            page_map[w] = '0;
          end
        end
        // The counter takes the reserved count even above the page total.
        pages_taken = resv;
      end
      REQ_ALLOC: begin
        // First fit: lowest clear bit below the page total.
        found = 1'b0;
        for (int w = 0; w * WORD_BITS < map_total && !found; w++) begin
          if (page_map[w] != '1) begin
            for (int b = 0; b < WORD_BITS && !found; b++) begin
              page = w * WORD_BITS + b;
              if (page < map_total && !page_map[w][b]) begin
                page_map[w][b] = 1'b1;
                pages_taken++;
                r.page_address = ADDR_W'(page) << PAGE_SHIFT;
                found = 1'b1;
              end
            end
          end
        end
        if (!found) r.status = STAT_OOM;
      end
      REQ_FREE: begin
        // Out of range and already free pages are left alone and flagged.
        page = int'(addr >> PAGE_SHIFT);
        if (page >= map_total) begin
          r.status = STAT_IGNORED;
        end else if (!page_map[page / WORD_BITS][page % WORD_BITS]) begin
          r.status = STAT_IGNORED;
        end else begin
          page_map[page / WORD_BITS][page % WORD_BITS] = 1'b0;
          if (pages_taken > 0) pages_taken--;
        end
      end
      default: ;
    endcase
    r.used_count = COUNT_W'(pages_taken);
    r.free_count = (map_total > pages_taken) ? COUNT_W'(map_total - pages_taken) : '0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. Inputs change at the falling edge; a beat is taken at the
  // rising edge where start is high and busy is low. The sender may idle for
  // a random number of cycles first, at the rate set for the current phase.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr,
                              output reply_t predicted);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start       <= 1'b1;
    in_req_type <= req;
    in_address  <= addr;
    do @(posedge clk); while (busy);
    predicted = predict_request(req, addr);
    replies_due.push_back(predicted);
  endtask

  // Drops start and waits until the block has answered everything.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (replies_due.size() != 0 || busy) @(posedge clk);
  endtask

  // Writes one register; only called once the block has settled.
  task automatic write_reg(input bpa_cfg_t idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == CFG_UPPER_KB) upper_kb_cfg = value[UPPER_KB_W-1:0];
    else reserved_cfg = value[RESV_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_memory(input int upper_kb, input int reserved);
    settle();
    write_reg(CFG_UPPER_KB, CFG_W'(upper_kb));
    write_reg(CFG_RESERVED, CFG_W'(reserved));
  endtask

  function automatic logic [ADDR_W-1:0] page_addr(input int page);
    return (ADDR_W'(page) << PAGE_SHIFT) | ADDR_W'($urandom_range(4095));
  endfunction

  // --------------------------------------------------------------------------
  // Result checker. Every result beat is matched against the oldest
  // prediction; the run carries on after a mismatch.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      reply_seen = '{out_page_address, bpa_stat_t'(out_status), out_used_count,
                     out_free_count};
      if (replies_due.size() == 0) begin
        $error("result beat with no request outstanding");
        error_count++;
      end else begin
        reply_due = replies_due.pop_front();
        if (reply_seen.page_address !== reply_due.page_address) begin
          $error("page_address: expected %h, got %h", reply_due.page_address,
                 reply_seen.page_address);
          error_count++;
        end
        if (reply_seen.status !== reply_due.status) begin
          $error("status: expected %0d, got %0d", reply_due.status, reply_seen.status);
          error_count++;
        end
        if (reply_seen.used_count !== reply_due.used_count) begin
          $error("used_count: expected %0d, got %0d", reply_due.used_count,
                 reply_seen.used_count);
          error_count++;
        end
        if (reply_seen.free_count !== reply_due.free_count) begin
          $error("free_count: expected %0d, got %0d", reply_due.free_count,
                 reply_seen.free_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: any accepted request or result beat restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Before the first init the page total is zero: allocation runs out of
  // memory and every free is out of range.
  task automatic test_before_init();
    reply_t r;
    send_request(REQ_ALLOC, 32'h0000_0000, r);
    send_request(REQ_FREE,  32'h0000_0000, r);
    send_request(REQ_NONE,  32'hFFFF_FFFF, r);
    send_request(REQ_FREE,  32'hFFFF_FFFF, r);
  endtask

  // Smallest map: no upper memory, minimum reservation, so nothing is free.
  task automatic test_smallest_map();
    reply_t r;
    set_memory(0, 256);
    send_request(REQ_INIT,  32'hFFFF_FFFF, r);
    send_request(REQ_ALLOC, 32'h0000_0000, r);
    send_request(REQ_FREE,  page_addr(255), r);
    send_request(REQ_ALLOC, 32'h1234_5678, r);
    send_request(REQ_FREE,  32'hFFFF_FFFF, r);
  endtask

  // Largest map, entirely reserved: a full scan, then the top page is
  // released, taken back, released twice, and a page past the top is freed.
  task automatic test_full_map();
    reply_t r;
    set_memory(UPPER_KB_HI, 65536);
    send_request(REQ_INIT,  32'h0000_0000, r);
    send_request(REQ_ALLOC, 32'h0000_0000, r);
    send_request(REQ_FREE,  page_addr(65535), r);
    send_request(REQ_ALLOC, 32'h0000_0000, r);
    send_request(REQ_FREE,  page_addr(65535), r);
    send_request(REQ_FREE,  page_addr(65535), r);
    send_request(REQ_FREE,  page_addr(65536), r);
  endtask

  // Reservation larger than the page total: the free count reads zero.
  task automatic test_overbooked();
    reply_t r;
    set_memory(0, 300);
    send_request(REQ_INIT,  32'h0000_0000, r);
    send_request(REQ_ALLOC, 32'h0000_0000, r);
    send_request(REQ_FREE,  page_addr(10), r);
    send_request(REQ_ALLOC, 32'h0000_0000, r);
    send_request(REQ_FREE,  page_addr(260), r);
  endtask

  // Register defaults: one allocation above the reserved area and back.
  task automatic test_defaults();
    reply_t r;
    set_memory(int'(UPPER_KB_RST), int'(RESV_RST));
    send_request(REQ_INIT,  32'h0000_0000, r);
    send_request(REQ_ALLOC, 32'h0000_0000, r);
    send_request(REQ_FREE,  r.page_address | 32'h0000_0FFF, r);
    send_request(REQ_NONE,  $urandom, r);
  endtask

  // --------------------------------------------------------------------------
  // Random traffic. Each segment writes new settings, initialises the map and
  // then runs a burst of allocations, frees, unused requests and re-inits.
  // Most segments use a small map near the reservation, so that allocations
  // scan few words and the map fills up and runs dry often; a few use wide
  // settings with a short burst. Frees mostly return pages that were handed
  // out, the rest hit random pages up to just past the top or any address.
  // --------------------------------------------------------------------------
  task automatic test_random_traffic(input int idle_pct, input int beats);
    reply_t r;
    int     sent;
    int     resv;
    int     total;
    int     ops;
    int     alloc_pct;
    int     pick;
    int     sel;
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] addr;
    int     live_pages [$];
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(9) == 0) begin
        resv = $urandom_range(256, 65536);
        set_memory($urandom_range(0, UPPER_KB_HI), resv);
        ops = $urandom_range(3, 8);
      end else begin
        resv  = $urandom_range(256, 1024);
        total = resv + $urandom_range(0, 72) - 8;
        if (total < 256) total = 256;
        set_memory(total * 4 - 1024 + $urandom_range(0, 3), resv);
        ops = $urandom_range(30, 80);
      end
      send_request(REQ_INIT, $urandom, r);
      sent++;
      live_pages.delete();
      alloc_pct = $urandom_range(30, 70);
      for (int n = 0; n < ops; n++) begin
        pick = $urandom_range(99);
        addr = $urandom;
        if (pick < alloc_pct) begin
          req = REQ_ALLOC;
        end else if (pick < 92) begin
          req = REQ_FREE;
          sel = $urandom_range(9);
          if (sel < 6 && live_pages.size() != 0) begin
            pick = $urandom_range(live_pages.size() - 1);
            addr = page_addr(live_pages[pick]);
            live_pages.delete(pick);
          end else if (sel < 9) begin
            addr = page_addr($urandom_range(0, map_total + 16));
          end
        end else if (pick < 97) begin
          req = REQ_NONE;
        end else begin
          req = REQ_INIT;
        end
        send_request(req, addr, r);
        sent++;
        if (req == REQ_INIT) live_pages.delete();
        if (req == REQ_ALLOC && r.status == STAT_DONE)
          live_pages.push_back(int'(r.page_address >> PAGE_SHIFT));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req_type = REQ_NONE;
    in_address  = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_UPPER_KB;
    cfg_wdata   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 7;
    test_before_init();
    test_smallest_map();
    test_full_map();
    test_overbooked();
    test_defaults();

    // The sender idles rarely, then often, then not at all.
    test_random_traffic(7, 530);
    test_random_traffic(67, 530);
    test_random_traffic(0, 540);

    // Drain the outstanding results, then keep watching the block in case
    // it produces a stray beat.
    settle();
    repeat (20) @(posedge clk);
    if (error_count == 0 && replies_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
